// ----- rtl/fpsc_pkg.sv -----
`default_nettype none
package fpsc_pkg;

    localparam int SPD_W      = 21;
    localparam int MAG_W      = 20;
    localparam int DUTY_W     = 16;
    localparam int INTEG_W    = 32;
    localparam int GAIN_W     = 16;
    localparam int LIM_W      = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;
    localparam int DIV_NUM_W  = 52;
    localparam int DIV_DEN_W  = 23;
    localparam int CLAMP_W    = 19;

    localparam logic [MAG_W-1:0]     MAG_MAX    = 20'd1048575;
    localparam logic [MAG_W-1:0]     DEADBAND   = 20'd256;
    localparam logic [MAG_W-1:0]     MEAS_GATE  = 20'd12800;
    localparam logic [LIM_W-1:0]     DUTY_NEAR_FULL = 15'd32736;
    localparam logic [LIM_W-1:0]     SAT_LOW    = 15'd32;
    localparam logic [CLAMP_W-1:0]   I_POS_NUM  = 19'd503316;
    localparam logic [CLAMP_W-1:0]   I_NEG_NUM  = 19'd167772;
    localparam logic [LIM_W-1:0]     DUTY_MAX   = 15'd32767;
    localparam logic [DUTY_W-1:0]    FF_MAX     = 16'd32768;
    localparam logic [INTEG_W-1:0]   INTEG_MAXP = 32'h7fff_ffff;
    localparam logic [INTEG_W-1:0]   INTEG_MINN = 32'h8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN,
        REG_INT_GAIN,
        REG_INT_GAIN_LOW,
        REG_LOW_SPEED_THR,
        REG_FF_RATE,
        REG_FF_OFFSET,
        REG_P_LIMIT,
        REG_STICTION
    } cfg_reg_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_RS_MUL,
        OP_RS_DIV,
        OP_RS_WB,
        OP_FF_DIV,
        OP_FF_WB,
        OP_POS_DIV,
        OP_POS_WB,
        OP_NEG_DIV,
        OP_NEG_WB,
        OP_INTEG,
        OP_MUL,
        OP_SUM,
        OP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
    } dp_status_t;

endpackage
`default_nettype wire

// ----- rtl/fpsc_if.sv -----
`default_nettype none
interface fpsc_speed_if
    import fpsc_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [SPD_W-1:0] target_speed;
    logic signed [SPD_W-1:0] measured_speed;

    modport source (output valid, output target_speed, output measured_speed, input ready);
    modport sink (input valid, input target_speed, input measured_speed, output ready);
endinterface

interface fpsc_duty_if
    import fpsc_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [DUTY_W-1:0] duty;

    modport source (output valid, output duty, input ready);
    modport sink (input valid, input duty, output ready);
endinterface
`default_nettype wire

// ----- rtl/fpsc_div.sv -----
`default_nettype none
module fpsc_div #(
    parameter int NUM_W = 52,
    parameter int DEN_W = 23
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic [NUM_W-1:0]      quo
);

    localparam int CNT_W = $clog2(NUM_W);

    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   rem_sh;
    logic             ge;
    logic [DEN_W:0]   rem_sub;

    // restoring division, one quotient bit a cycle
    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[NUM_W-1]};
        ge      = rem_sh >= {1'b0, den_reg};
        rem_sub = rem_sh - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
            rem_reg <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule
`default_nettype wire

// ----- rtl/fpsc_datapath.sv -----
`default_nettype none
module fpsc_datapath
    import fpsc_pkg::*;
#(
    parameter int EMA_SHIFT = 3
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire dp_cmd_t                   cmd,
    output dp_status_t                     status,
    input  wire logic signed [SPD_W-1:0]   target_speed,
    input  wire logic signed [SPD_W-1:0]   measured_speed,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [CFG_DATA_W-1:0]     cfg_data,
    output logic signed [DUTY_W-1:0]       duty
);

    localparam int ACC_W = MAG_W + EMA_SHIFT + 1;
    localparam logic [ACC_W-1:0] EMA_ROUND = (ACC_W'(1) << EMA_SHIFT) >> 1;

    // configuration
    logic [GAIN_W-1:0]            prop_gain_reg, int_gain_reg, int_gain_low_reg, ff_rate_reg;
    logic [MAG_W-1:0]             low_thr_reg;
    logic signed [SPD_W-1:0]      ff_offset_reg;
    logic [LIM_W-1:0]             p_limit_reg, stiction_reg;

    // loop state
    logic signed [INTEG_W-1:0]    integ_reg, integ_next;
    logic [MAG_W-1:0]             filt_reg;
    logic signed [DUTY_W-1:0]     last_duty_reg;
    logic [MAG_W-1:0]             last_tmag_reg;
    logic                         primed_reg;

    // per-tick work registers
    logic [MAG_W-1:0]             t_reg;
    logic                         tgt_neg_reg;
    logic [DIV_NUM_W-1:0]         prod_reg;
    logic                         prod_neg_reg;
    logic signed [SPD_W-1:0]      err_reg;
    logic [GAIN_W-1:0]            k_reg;
    logic [DUTY_W-1:0]            ff_reg;
    logic [CLAMP_W-1:0]           pos_reg, neg_reg;
    logic signed [37:0]           pmul_reg;
    logic signed [48:0]           imul_reg;
    logic signed [42:0]           dsum_reg;
    logic signed [DUTY_W-1:0]     duty_reg;

    logic [MAG_W-1:0]             t_in, m_in;
    logic [ACC_W-1:0]             acc;
    logic [INTEG_W-1:0]           integ_abs;
    logic                         div_start;
    logic [DIV_NUM_W-1:0]         div_num, div_q;
    logic [DIV_DEN_W-1:0]         div_den, ff_den;
    logic                         div_done;
    logic signed [21:0]           ff_sum;
    logic [GAIN_W-1:0]            kd;
    logic [LIM_W-1:0]             dmag;
    logic                         do_integ;
    logic signed [INTEG_W:0]      isum;
    logic signed [37:0]           pmul_next;
    logic signed [48:0]           imul_next;
    logic signed [40:0]           p_rnd, i_rnd;
    logic signed [16:0]           p_clamped;
    logic signed [42:0]           dsum_next;
    logic signed [42:0]           d_st;
    logic [LIM_W-1:0]             d_mag;
    logic signed [DUTY_W-1:0]     duty_next;

    function automatic logic [MAG_W-1:0] mag20(input logic signed [SPD_W-1:0] v);
        logic [SPD_W-1:0] a;
        a = v[SPD_W-1] ? SPD_W'(-v) : SPD_W'(v);
        return a[SPD_W-1] ? MAG_MAX : a[MAG_W-1:0];
    endfunction

    // shift right by 9 with rounding half away from zero
    function automatic logic signed [40:0] round9(input logic signed [48:0] v);
        logic [48:0] m;
        logic [49:0] s;
        logic [40:0] r;
        m = v[48] ? 49'(-v) : 49'(v);
        s = {1'b0, m} + 50'd256;
        r = s[49:9];
        return v[48] ? $signed(41'(-r)) : $signed(r);
    endfunction

    fpsc_div #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (DIV_DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_q)
    );

    assign status.div_done = div_done;

    always_comb
    begin
        t_in = mag20(target_speed);
        m_in = mag20(measured_speed);
        acc  = (ACC_W'(filt_reg) << EMA_SHIFT) - ACC_W'(filt_reg) + ACC_W'(m_in) + EMA_ROUND;

        integ_abs = integ_reg[INTEG_W-1] ? INTEG_W'(-integ_reg) : INTEG_W'(integ_reg);
        ff_sum    = $signed({2'b00, t_reg}) + 22'(ff_offset_reg);
        ff_den    = DIV_DEN_W'(ff_rate_reg) * DIV_DEN_W'(100);
        kd        = (k_reg == '0) ? GAIN_W'(1) : k_reg;

        div_start = 1'b0;
        div_num   = prod_reg;
        div_den   = (last_tmag_reg == '0) ? DIV_DEN_W'(1) : DIV_DEN_W'(last_tmag_reg);
        case (cmd.op)
            OP_RS_DIV:
            begin
                div_start = 1'b1;
            end
            OP_FF_DIV:
            begin
                div_start = 1'b1;
                div_num   = (ff_sum > 0) ? DIV_NUM_W'({ff_sum[20:0], 15'd0}) : '0;
                div_den   = (ff_den == '0) ? DIV_DEN_W'(1) : ff_den;
            end
            OP_POS_DIV:
            begin
                div_start = 1'b1;
                div_num   = DIV_NUM_W'(I_POS_NUM);
                div_den   = DIV_DEN_W'(kd);
            end
            OP_NEG_DIV:
            begin
                div_start = 1'b1;
                div_num   = DIV_NUM_W'(I_NEG_NUM);
                div_den   = DIV_DEN_W'(kd);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase

        // anti-windup gating
        dmag     = last_duty_reg[DUTY_W-1] ? LIM_W'(-last_duty_reg) : last_duty_reg[LIM_W-1:0];
        do_integ = !(dmag >= DUTY_NEAR_FULL && err_reg > 0) && !(dmag <= SAT_LOW && err_reg < 0)
                   && (filt_reg > MEAS_GATE);
        isum     = 33'(integ_reg) + 33'(err_reg);
        pmul_next = $signed({1'b0, prop_gain_reg}) * err_reg;
        imul_next = $signed({1'b0, k_reg}) * integ_reg;

        integ_next = integ_reg;
        case (cmd.op)
            OP_RS_WB:
            begin
                if (primed_reg && last_tmag_reg > DEADBAND && t_reg > DEADBAND)
                begin
                    if (prod_neg_reg)
                        integ_next = (div_q > DIV_NUM_W'(INTEG_MINN)) ? $signed(INTEG_MINN)
                                     : $signed(INTEG_W'(-div_q[INTEG_W-1:0]));
                    else
                        integ_next = (div_q > DIV_NUM_W'(INTEG_MAXP)) ? $signed(INTEG_MAXP)
                                     : $signed(div_q[INTEG_W-1:0]);
                end
                else if (t_reg <= DEADBAND)
                    integ_next = '0;
            end
            OP_INTEG:
            begin
                if (do_integ)
                begin
                    if (isum > $signed({14'd0, pos_reg}))
                        integ_next = INTEG_W'($signed({1'b0, pos_reg}));
                    else if (isum < -$signed({14'd0, neg_reg}))
                        integ_next = -INTEG_W'($signed({1'b0, neg_reg}));
                    else
                        integ_next = isum[INTEG_W-1:0];
                end
            end
            default:
            begin
                integ_next = integ_reg;
            end
        endcase

        p_rnd = (filt_reg == '0) ? '0 : round9(49'(pmul_reg));
        if (p_rnd > $signed({26'd0, p_limit_reg}))
            p_clamped = $signed({2'b00, p_limit_reg});
        else if (p_rnd < -$signed({26'd0, p_limit_reg}))
            p_clamped = -$signed({2'b00, p_limit_reg});
        else
            p_clamped = p_rnd[16:0];
        i_rnd     = round9(imul_reg);
        dsum_next = $signed({27'd0, ff_reg}) + 43'(p_clamped) + 43'(i_rnd);

        // stiction floor, saturation, sign
        d_st = dsum_reg;
        if (t_reg != '0 && dsum_reg > 0 && dsum_reg < $signed({28'd0, stiction_reg}))
            d_st = $signed({28'd0, stiction_reg});
        if (d_st < 0)
            d_mag = '0;
        else if (d_st > $signed({28'd0, DUTY_MAX}))
            d_mag = DUTY_MAX;
        else
            d_mag = d_st[LIM_W-1:0];
        if (t_reg == '0)
            duty_next = '0;
        else if (tgt_neg_reg)
            duty_next = -$signed({1'b0, d_mag});
        else
            duty_next = $signed({1'b0, d_mag});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg    <= '0;
            int_gain_reg     <= '0;
            int_gain_low_reg <= '0;
            low_thr_reg      <= '0;
            ff_rate_reg      <= '0;
            ff_offset_reg    <= '0;
            p_limit_reg      <= DUTY_MAX;
            stiction_reg     <= '0;
            integ_reg        <= '0;
            filt_reg         <= '0;
            last_duty_reg    <= '0;
            last_tmag_reg    <= '0;
            primed_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_PROP_GAIN:     prop_gain_reg    <= cfg_data[GAIN_W-1:0];
                    REG_INT_GAIN:      int_gain_reg     <= cfg_data[GAIN_W-1:0];
                    REG_INT_GAIN_LOW:  int_gain_low_reg <= cfg_data[GAIN_W-1:0];
                    REG_LOW_SPEED_THR: low_thr_reg      <= cfg_data[MAG_W-1:0];
                    REG_FF_RATE:       ff_rate_reg      <= cfg_data[GAIN_W-1:0];
                    REG_FF_OFFSET:     ff_offset_reg    <= $signed(cfg_data);
                    REG_P_LIMIT:       p_limit_reg      <= cfg_data[LIM_W-1:0];
                    REG_STICTION:      stiction_reg     <= cfg_data[LIM_W-1:0];
                    default:           prop_gain_reg    <= prop_gain_reg;
                endcase
            end
            integ_reg <= integ_next;
            if (cmd.op == OP_LOAD)
                filt_reg <= MAG_W'(acc >> EMA_SHIFT);
            if (cmd.op == OP_RS_WB)
                last_tmag_reg <= t_reg;
            if (cmd.op == OP_FINISH)
            begin
                last_duty_reg <= duty_next;
                primed_reg    <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                t_reg       <= t_in;
                tgt_neg_reg <= target_speed[SPD_W-1];
            end
            OP_RS_MUL:
            begin
                prod_reg     <= DIV_NUM_W'(integ_abs) * DIV_NUM_W'(t_reg);
                prod_neg_reg <= integ_reg[INTEG_W-1];
                err_reg      <= $signed({1'b0, t_reg}) - $signed({1'b0, filt_reg});
                k_reg        <= (t_reg < low_thr_reg) ? int_gain_low_reg : int_gain_reg;
            end
            OP_FF_WB:
            begin
                if (ff_rate_reg != '0 && t_reg != '0 && ff_sum > 0)
                    ff_reg <= (div_q > DIV_NUM_W'(FF_MAX)) ? FF_MAX : div_q[DUTY_W-1:0];
                else
                    ff_reg <= '0;
            end
            OP_POS_WB:  pos_reg  <= div_q[CLAMP_W-1:0];
            OP_NEG_WB:  neg_reg  <= div_q[CLAMP_W-1:0];
            OP_INTEG:   pmul_reg <= pmul_next;
            OP_MUL:     imul_reg <= imul_next;
            OP_SUM:     dsum_reg <= dsum_next;
            OP_FINISH:  duty_reg <= duty_next;
            default:    duty_reg <= duty_reg;
        endcase
    end

    assign duty = duty_reg;

    a_last_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        last_duty_reg != $signed(16'h8000))
        else $error("last duty left the saturated range");

    a_deadband_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_RS_WB && t_reg <= DEADBAND) |=> integ_reg == '0)
        else $error("integrator not cleared inside deadband");

endmodule
`default_nettype wire

// ----- rtl/fpsc_ctrl.sv -----
`default_nettype none
module fpsc_ctrl
    import fpsc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    output dp_cmd_t         cmd,
    input  wire dp_status_t status
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_RS_MUL,
        S_RS_DIV,
        S_RS_WAIT,
        S_RS_WB,
        S_FF_DIV,
        S_FF_WAIT,
        S_FF_WB,
        S_POS_DIV,
        S_POS_WAIT,
        S_POS_WB,
        S_NEG_DIV,
        S_NEG_WAIT,
        S_NEG_WB,
        S_INTEG,
        S_MUL,
        S_SUM,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    always_comb
    begin
        out_free       = !out_valid_reg || out_ready;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_RS_MUL;
                end
            end
            S_RS_MUL:
            begin
                cmd.op     = OP_RS_MUL;
                state_next = S_RS_DIV;
            end
            S_RS_DIV:
            begin
                cmd.op     = OP_RS_DIV;
                state_next = S_RS_WAIT;
            end
            S_RS_WAIT:  if (status.div_done) state_next = S_RS_WB;
            S_RS_WB:
            begin
                cmd.op     = OP_RS_WB;
                state_next = S_FF_DIV;
            end
            S_FF_DIV:
            begin
                cmd.op     = OP_FF_DIV;
                state_next = S_FF_WAIT;
            end
            S_FF_WAIT:  if (status.div_done) state_next = S_FF_WB;
            S_FF_WB:
            begin
                cmd.op     = OP_FF_WB;
                state_next = S_POS_DIV;
            end
            S_POS_DIV:
            begin
                cmd.op     = OP_POS_DIV;
                state_next = S_POS_WAIT;
            end
            S_POS_WAIT: if (status.div_done) state_next = S_POS_WB;
            S_POS_WB:
            begin
                cmd.op     = OP_POS_WB;
                state_next = S_NEG_DIV;
            end
            S_NEG_DIV:
            begin
                cmd.op     = OP_NEG_DIV;
                state_next = S_NEG_WAIT;
            end
            S_NEG_WAIT: if (status.div_done) state_next = S_NEG_WB;
            S_NEG_WB:
            begin
                cmd.op     = OP_NEG_WB;
                state_next = S_INTEG;
            end
            S_INTEG:
            begin
                cmd.op     = OP_INTEG;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.op     = OP_MUL;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.op     = OP_SUM;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // wait for the output register to free up
                if (out_free)
                begin
                    cmd.op         = OP_FINISH;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> (state_reg == S_RS_WAIT || state_reg == S_FF_WAIT ||
                             state_reg == S_POS_WAIT || state_reg == S_NEG_WAIT))
        else $error("divider finished outside a wait state");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> state_reg == S_RS_MUL)
        else $error("accepted word did not start a tick");

    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result shown without finishing a tick");

endmodule
`default_nettype wire

// ----- rtl/feedforward_pi_speed_controller_core.sv -----
`default_nettype none
// Feed-forward plus PI speed controller with target-scheduled integral gain and
// anti-windup. One word on speed (signed target and raw measured speed, 1/256 Hz)
// gives one signed Q1.15 duty word on drive. Within a tick the integrator rescale,
// the feed-forward quotient and the two integrator clamp limits each go through
// one shared radix-2 divider, with a start and a write-back step around each. A
// new speed word is taken once the previous tick has placed its duty in the
// output register, even if that duty has not been taken yet. Configuration
// writes are taken at any cycle with cfg_we high and must only be issued while
// the block is idle.
module feedforward_pi_speed_controller_core
    import fpsc_pkg::*;
#(
    parameter int EMA_SHIFT = 3
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    fpsc_speed_if.sink                 speed,
    fpsc_duty_if.source                drive,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    fpsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (speed.valid),
        .in_ready  (speed.ready),
        .out_valid (drive.valid),
        .out_ready (drive.ready),
        .cmd       (cmd),
        .status    (status)
    );

    fpsc_datapath #(
        .EMA_SHIFT (EMA_SHIFT)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .target_speed   (speed.target_speed),
        .measured_speed (speed.measured_speed),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .duty           (drive.duty)
    );

endmodule
`default_nettype wire
